/* rtl/spib_pkg.sv */
// Shared types and constants for the servo instruction packet builder.
// Used by the front decoder, the command queue and the byte serializer.
package spib_pkg;

    // Command operation codes as they arrive on the input port.
    typedef enum logic [3:0] {
        OP_PING        = 4'd0,
        OP_READ_VOLT   = 4'd1,
        OP_READ_TEMP   = 4'd2,
        OP_READ_POS    = 4'd3,
        OP_READ_SPEED  = 4'd4,
        OP_LED         = 4'd5,
        OP_SET_ID      = 4'd6,
        OP_TORQUE      = 4'd7,
        OP_RETURN_LVL  = 4'd8,
        OP_MOVE        = 4'd9,
        OP_MOVE_SPEED  = 4'd10,
        OP_REG_MOVE    = 4'd11,
        OP_ACTION      = 4'd12,
        OP_RESET       = 4'd13
    } op_t;

    // Bus instruction codes.
    localparam logic [7:0] INS_PING      = 8'd1;
    localparam logic [7:0] INS_READ      = 8'd2;
    localparam logic [7:0] INS_WRITE     = 8'd3;
    localparam logic [7:0] INS_REG_WRITE = 8'd4;
    localparam logic [7:0] INS_ACTION    = 8'd5;
    localparam logic [7:0] INS_RESET     = 8'd6;

    // Control table addresses.
    localparam logic [7:0] ADDR_ID         = 8'd3;
    localparam logic [7:0] ADDR_RETURN_LVL = 8'd16;
    localparam logic [7:0] ADDR_TORQUE     = 8'd24;
    localparam logic [7:0] ADDR_LED        = 8'd25;
    localparam logic [7:0] ADDR_GOAL_POS   = 8'd30;
    localparam logic [7:0] ADDR_POS        = 8'd36;
    localparam logic [7:0] ADDR_SPEED      = 8'd38;
    localparam logic [7:0] ADDR_VOLT       = 8'd42;
    localparam logic [7:0] ADDR_TEMP       = 8'd43;

    // Fixed packet bytes.
    localparam logic [7:0] START_BYTE = 8'hFF;
    localparam logic [7:0] ALL_SERVOS = 8'd254;

    // Length field values.
    localparam logic [7:0] LEN_NONE  = 8'd2;
    localparam logic [7:0] LEN_PAIR  = 8'd4;
    localparam logic [7:0] LEN_MOVE  = 8'd5;
    localparam logic [7:0] LEN_MOVE_SPEED = 8'd7;

    // Byte positions within a packet.
    localparam int         PARAM_CNT   = 5;
    localparam int         PCOUNT_W    = 3;
    localparam int         IDX_W       = 4;
    localparam logic [3:0] IDX_START0  = 4'd0;
    localparam logic [3:0] IDX_START1  = 4'd1;
    localparam logic [3:0] IDX_ID      = 4'd2;
    localparam logic [3:0] IDX_LEN     = 4'd3;
    localparam logic [3:0] IDX_INS     = 4'd4;
    localparam logic [3:0] IDX_PARAM0  = 4'd5;
    localparam logic [3:0] IDX_PARAM1  = 4'd6;
    localparam logic [3:0] IDX_PARAM2  = 4'd7;
    localparam logic [3:0] IDX_PARAM3  = 4'd8;
    localparam logic [3:0] IDX_PARAM4  = 4'd9;

    // One classified command, ready for serialization.
    typedef struct packed {
        logic [7:0]                 id;
        logic [7:0]                 len;
        logic [7:0]                 ins;
        logic [PARAM_CNT-1:0][7:0]  params;
        logic [PCOUNT_W-1:0]        pcount;
    } desc_t;

endpackage

/* rtl/spib_front.sv */
// Front end: classifies an incoming servo command into a packet descriptor.
// Depends on spib_pkg for the operation codes and the descriptor type.
module spib_front
    import spib_pkg::*;
(
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  operation,
    input  logic [7:0]  servo_id,
    input  logic [15:0] argument,
    input  logic [15:0] speed,
    input  logic        queue_full,
    output logic        push,
    output desc_t       push_desc
);

    logic [7:0] arg_lo;
    logic [7:0] arg_hi;
    logic       op_ok;

    assign arg_lo = argument[7:0];
    assign arg_hi = argument[15:8];

    // Decode the operation into header fields and parameter bytes.
    always_comb
    begin
        push_desc        = '0;
        push_desc.id     = servo_id;
        push_desc.len    = LEN_NONE;
        push_desc.ins    = INS_PING;
        op_ok            = 1'b1;
        case (op_t'(operation))
            OP_PING:
            begin
                push_desc.ins = INS_PING;
            end
            OP_READ_VOLT, OP_READ_TEMP, OP_READ_POS, OP_READ_SPEED:
            begin
                push_desc.len       = LEN_PAIR;
                push_desc.ins       = INS_READ;
                push_desc.pcount    = PCOUNT_W'(2);
                if (op_t'(operation) == OP_READ_VOLT)
                begin
                    push_desc.params[0] = ADDR_VOLT;
                    push_desc.params[1] = 8'd1;
                end
                else if (op_t'(operation) == OP_READ_TEMP)
                begin
                    push_desc.params[0] = ADDR_TEMP;
                    push_desc.params[1] = 8'd1;
                end
                else if (op_t'(operation) == OP_READ_POS)
                begin
                    push_desc.params[0] = ADDR_POS;
                    push_desc.params[1] = 8'd2;
                end
                else
                begin
                    push_desc.params[0] = ADDR_SPEED;
                    push_desc.params[1] = 8'd2;
                end
            end
            OP_LED, OP_SET_ID, OP_TORQUE, OP_RETURN_LVL:
            begin
                push_desc.len       = LEN_PAIR;
                push_desc.ins       = INS_WRITE;
                push_desc.pcount    = PCOUNT_W'(2);
                push_desc.params[1] = arg_lo;
                if (op_t'(operation) == OP_LED)
                    push_desc.params[0] = ADDR_LED;
                else if (op_t'(operation) == OP_SET_ID)
                    push_desc.params[0] = ADDR_ID;
                else if (op_t'(operation) == OP_TORQUE)
                    push_desc.params[0] = ADDR_TORQUE;
                else
                    push_desc.params[0] = ADDR_RETURN_LVL;
            end
            OP_MOVE:
            begin
                push_desc.len       = LEN_MOVE;
                push_desc.ins       = INS_WRITE;
                push_desc.pcount    = PCOUNT_W'(3);
                push_desc.params[0] = ADDR_GOAL_POS;
                push_desc.params[1] = arg_lo;
                push_desc.params[2] = arg_hi;
            end
            OP_MOVE_SPEED, OP_REG_MOVE:
            begin
                push_desc.len       = LEN_MOVE_SPEED;
                push_desc.ins       = (op_t'(operation) == OP_MOVE_SPEED) ?
                                      INS_WRITE : INS_REG_WRITE;
                push_desc.pcount    = PCOUNT_W'(5);
                push_desc.params[0] = ADDR_GOAL_POS;
                push_desc.params[1] = arg_lo;
                push_desc.params[2] = arg_hi;
                push_desc.params[3] = speed[7:0];
                push_desc.params[4] = speed[15:8];
            end
            OP_ACTION:
            begin
                push_desc.id  = ALL_SERVOS;
                push_desc.ins = INS_ACTION;
            end
            OP_RESET:
            begin
                push_desc.ins = INS_RESET;
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
    end

    // Unused codes are accepted and dropped; valid ones go into the queue.
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full && op_ok;

endmodule

/* rtl/spib_queue.sv */
// Short descriptor queue between the command decoder and the serializer.
// Depends on spib_pkg for the descriptor type.
module spib_queue
    import spib_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output desc_t head_desc
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = entry_reg[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage holds payload only and needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    // The queue never overflows or underflows.
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue holds more items than its depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push while queue full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop while queue empty");

endmodule

/* rtl/spib_back.sv */
// Back end: serializes the head descriptor into packet bytes with checksum.
// Depends on spib_pkg for the descriptor type and byte position constants.
module spib_back
    import spib_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  desc_t      head_desc,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] packet_byte,
    output logic       last_byte
);

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic [IDX_W-1:0] last_idx;
    logic             is_last;
    logic             summed;
    logic             load;
    logic [7:0]       cur_byte;

    // The checksum follows the header and the parameter bytes.
    assign last_idx = IDX_PARAM0 + IDX_W'(head_desc.pcount);
    assign is_last  = (idx_reg == last_idx);
    assign summed   = (idx_reg >= IDX_ID) && !is_last;
    assign load     = head_valid && (!out_valid_reg || !out_stall);
    assign pop      = load && is_last;

    // Select the byte at the current position.
    always_comb
    begin
        if (is_last)
            cur_byte = ~sum_reg;
        else
        begin
            case (idx_reg)
                IDX_START0: cur_byte = START_BYTE;
                IDX_START1: cur_byte = START_BYTE;
                IDX_ID:     cur_byte = head_desc.id;
                IDX_LEN:    cur_byte = head_desc.len;
                IDX_INS:    cur_byte = head_desc.ins;
                IDX_PARAM0: cur_byte = head_desc.params[0];
                IDX_PARAM1: cur_byte = head_desc.params[1];
                IDX_PARAM2: cur_byte = head_desc.params[2];
                IDX_PARAM3: cur_byte = head_desc.params[3];
                IDX_PARAM4: cur_byte = head_desc.params[4];
                default:    cur_byte = START_BYTE;
            endcase
        end
    end

    // Position, running sum and output valid.
    always_comb
    begin
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (is_last)
            begin
                idx_next = '0;
                sum_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
                if (summed)
                    sum_next = sum_reg + cur_byte;
            end
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= cur_byte;
            last_reg <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign packet_byte = byte_reg;
    assign last_byte   = last_reg;

    // The position stays within the packet of the item being sent.
    a_idx_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg <= last_idx))
        else $error("byte position beyond the end of the packet");

    a_idx_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (idx_reg == '0 && sum_reg == '0))
        else $error("serializer not at packet start while idle");

    // A stalled output item stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(packet_byte) && $stable(last_byte)))
        else $error("output item changed while stalled");

endmodule

/* rtl/servo_instruction_packet_builder_core.sv */
// Top level of the servo instruction packet builder.
// Depends on spib_pkg, spib_front, spib_queue and spib_back.
//
// Each accepted command produces one complete instruction packet on the
// output channel, one byte per item, with last_byte set on the checksum.
// Packets are 6 bytes (ping, action, reset), 8 bytes (reads and byte
// writes), 9 bytes (move) or 11 bytes (move with speed), and the block
// delivers one byte per cycle while the output is not stalled;
// consecutive queued packets follow with no gap. The rate is set by the
// back-end serializer, which walks the packet one byte position a cycle
// into its output register. Commands are decoded as they arrive and wait
// in a queue of QUEUE_DEPTH entries, so the input takes a new command in
// the next cycle until the queue fills. Operation codes 14 and 15 are
// accepted and produce no bytes. The first byte of a packet passes
// through the queue entry and then the serializer output register.
module servo_instruction_packet_builder_core
    import spib_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  operation,
    input  logic [7:0]  servo_id,
    input  logic [15:0] argument,
    input  logic [15:0] speed,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  packet_byte,
    output logic        last_byte
);

    logic  push;
    desc_t push_desc;
    logic  queue_full;
    logic  pop;
    logic  head_valid;
    desc_t head_desc;

    // Command decode.
    spib_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .servo_id   (servo_id),
        .argument   (argument),
        .speed      (speed),
        .queue_full (queue_full),
        .push       (push),
        .push_desc  (push_desc)
    );

    // Descriptor queue.
    spib_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    // Byte serializer.
    spib_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_desc   (head_desc),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .packet_byte (packet_byte),
        .last_byte   (last_byte)
    );

endmodule

/* verif/tb_servo_instruction_packet_builder_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for servo_instruction_packet_builder_core.
// Depends on spib_pkg and the core RTL. It predicts every packet byte from the
// accepted commands and compares the byte stream under random idling and back pressure.
module tb_servo_instruction_packet_builder_core
    import spib_pkg::*;
();

    // Operation codes that the block accepts but turns into no packet.
    localparam logic [3:0] OP_UNUSED_FIRST = 4'd14;
    localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 30;

    typedef struct packed {
        logic [3:0]  op;
        logic [7:0]  id;
        logic [15:0] arg;
        logic [15:0] spd;
    } servo_cmd_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } bus_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [3:0]  operation = '0;
    logic [7:0]  servo_id = '0;
    logic [15:0] argument = '0;
    logic [15:0] speed = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  packet_byte;
    logic        last_byte;

    servo_cmd_t command_queue [$];
    bus_byte_t  expected_bytes [$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         phase = 0;
    logic       hold_off = 1'b0;

    servo_instruction_packet_builder_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .servo_id    (servo_id),
        .argument    (argument),
        .speed       (speed),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .packet_byte (packet_byte),
        .last_byte   (last_byte)
    );

    always #5 clk = ~clk;

    // Build the instruction packet that one command produces and queue its bytes.
    task automatic predict_packet(input servo_cmd_t cmd);
        logic [7:0] pid;
        logic [7:0] plen;
        logic [7:0] pins;
        logic [7:0] prm [0:4];
        logic [7:0] csum;
        int         nprm;
        begin
            pid  = cmd.id;
            plen = LEN_NONE;
            pins = INS_PING;
            nprm = 0;
            case (cmd.op)
                OP_PING:
                    pins = INS_PING;
                OP_READ_VOLT, OP_READ_TEMP, OP_READ_POS, OP_READ_SPEED:
                begin
                    plen = LEN_PAIR;
                    pins = INS_READ;
                    nprm = 2;
                    // Voltage and temperature are one byte wide, position and speed two.
                    case (cmd.op)
                        OP_READ_VOLT: prm[0] = ADDR_VOLT;
                        OP_READ_TEMP: prm[0] = ADDR_TEMP;
                        OP_READ_POS:  prm[0] = ADDR_POS;
                        default:      prm[0] = ADDR_SPEED;
                    endcase
                    prm[1] = (cmd.op == OP_READ_VOLT || cmd.op == OP_READ_TEMP) ? 8'd1 : 8'd2;
                end
                OP_LED, OP_SET_ID, OP_TORQUE, OP_RETURN_LVL:
                begin
                    plen = LEN_PAIR;
                    pins = INS_WRITE;
                    nprm = 2;
                    case (cmd.op)
                        OP_LED:    prm[0] = ADDR_LED;
                        OP_SET_ID: prm[0] = ADDR_ID;
                        OP_TORQUE: prm[0] = ADDR_TORQUE;
                        default:   prm[0] = ADDR_RETURN_LVL;
                    endcase
                    prm[1] = cmd.arg[7:0];
                end
                OP_MOVE:
                begin
                    plen   = LEN_MOVE;
                    pins   = INS_WRITE;
                    nprm   = 3;
                    prm[0] = ADDR_GOAL_POS;
                    prm[1] = cmd.arg[7:0];
                    prm[2] = cmd.arg[15:8];
                end
                OP_MOVE_SPEED, OP_REG_MOVE:
                begin
                    plen   = LEN_MOVE_SPEED;
                    pins   = (cmd.op == OP_REG_MOVE) ? INS_REG_WRITE : INS_WRITE;
                    nprm   = 5;
                    prm[0] = ADDR_GOAL_POS;
                    prm[1] = cmd.arg[7:0];
                    prm[2] = cmd.arg[15:8];
                    prm[3] = cmd.spd[7:0];
                    prm[4] = cmd.spd[15:8];
                end
                OP_ACTION:
                begin
                    // Action always goes out to every servo.
                    pid  = ALL_SERVOS;
                    pins = INS_ACTION;
                end
                OP_RESET:
                    pins = INS_RESET;
                default:
                    return;
            endcase

            // The checksum covers everything from the id to the last parameter.
            csum = pid + plen + pins;
            for (int i = 0; i < nprm; i++)
                csum = csum + prm[i];

            expected_bytes.push_back({START_BYTE, 1'b0});
            expected_bytes.push_back({START_BYTE, 1'b0});
            expected_bytes.push_back({pid, 1'b0});
            expected_bytes.push_back({plen, 1'b0});
            expected_bytes.push_back({pins, 1'b0});
            for (int i = 0; i < nprm; i++)
                expected_bytes.push_back({prm[i], 1'b0});
            expected_bytes.push_back({~csum, 1'b1});
        end
    endtask

    task automatic queue_command(input logic [3:0] op, input logic [7:0] id,
                                 input logic [15:0] arg, input logic [15:0] spd);
        servo_cmd_t c;
        begin
            c.op  = op;
            c.id  = id;
            c.arg = arg;
            c.spd = spd;
            command_queue.push_back(c);
        end
    endtask

    // Random commands; unused codes are mixed in but do not count toward the total.
    task automatic queue_random(input int count);
        servo_cmd_t c;
        int         made;
        begin
            made = 0;
            while (made < count)
            begin
                if ($urandom_range(19) == 0)
                    c.op = 4'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
                else
                    c.op = 4'($urandom_range(int'(OP_RESET)));
                c.id = ($urandom_range(9) == 0) ? ALL_SERVOS : 8'($urandom_range(254));
                if ($urandom_range(7) == 0)
                    c.arg = {16{$urandom_range(1) == 1}};
                else
                    c.arg = 16'($urandom_range(65535));
                if ($urandom_range(7) == 0)
                    c.spd = {16{$urandom_range(1) == 1}};
                else
                    c.spd = 16'($urandom_range(65535));
                if (c.op <= OP_RESET)
                    made++;
                command_queue.push_back(c);
            end
        end
    endtask

    // Command driver: predicts on acceptance, then offers the next item or idles.
    always @(posedge clk)
    begin : command_driver
        servo_cmd_t active_cmd;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                active_cmd.op  = operation;
                active_cmd.id  = servo_id;
                active_cmd.arg = argument;
                active_cmd.spd = speed;
                predict_packet(active_cmd);
            end
            if (!in_valid || !in_stall)
            begin
                if (command_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    active_cmd = command_queue.pop_front();
                    in_valid  <= 1'b1;
                    operation <= active_cmd.op;
                    servo_id  <= active_cmd.id;
                    argument  <= active_cmd.arg;
                    speed     <= active_cmd.spd;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Byte monitor: checks each accepted byte against the oldest expectation.
    always @(posedge clk)
    begin : byte_monitor
        bus_byte_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("Unexpected byte: packet_byte %02h last_byte %0b",
                                 packet_byte, last_byte);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (packet_byte !== want.value || last_byte !== want.last)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("Byte mismatch: expected %02h/%0b, got %02h/%0b",
                                     want.value, want.last, packet_byte, last_byte);
                    end
                end
            end
            out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Long receiver hold-off in the last phase so the command queue fills up.
    initial
    begin : hold_off_proc
        wait (phase == 2);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus sequence: reset, then three idling phases.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 15;
                    recv_idle_pct = 85;
                end
                1:
                begin
                    send_idle_pct = 85;
                    recv_idle_pct = 15;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            if (phase == 0)
            begin
                // Every operation at least once, field extremes and checksum corner values.
                queue_command(OP_PING,       8'd0,   16'h0000, 16'h0000);
                queue_command(OP_PING,       8'd252, 16'hFFFF, 16'hFFFF);
                queue_command(OP_PING,       8'd253, 16'h0000, 16'h0000);
                queue_command(OP_READ_VOLT,  8'd254, 16'h0000, 16'h0000);
                queue_command(OP_READ_TEMP,  8'd1,   16'hFFFF, 16'h0000);
                queue_command(OP_READ_POS,   8'h55,  16'h0000, 16'hFFFF);
                queue_command(OP_READ_SPEED, 8'hAA,  16'hA5A5, 16'h5A5A);
                queue_command(OP_LED,        8'd10,  16'hFF01, 16'h0000);
                queue_command(OP_SET_ID,     8'd20,  16'h00FE, 16'h0000);
                queue_command(OP_TORQUE,     8'd30,  16'hFFFF, 16'h0000);
                queue_command(OP_RETURN_LVL, 8'd254, 16'h0002, 16'h0000);
                queue_command(OP_MOVE,       8'd254, 16'h0000, 16'h0000);
                queue_command(OP_MOVE,       8'd0,   16'hFFFF, 16'hFFFF);
                queue_command(OP_MOVE_SPEED, 8'd7,   16'h03FF, 16'hFFFF);
                queue_command(OP_MOVE_SPEED, 8'd254, 16'hFFFF, 16'h0000);
                queue_command(OP_REG_MOVE,   8'd127, 16'h1234, 16'h8001);
                queue_command(OP_REG_MOVE,   8'd254, 16'hFFFF, 16'hFFFF);
                queue_command(OP_ACTION,     8'd7,   16'hFFFF, 16'hFFFF);
                queue_command(OP_ACTION,     8'd254, 16'h0000, 16'h0000);
                queue_command(OP_RESET,      8'd254, 16'h0000, 16'h0000);
                queue_command(OP_RESET,      8'd0,   16'hFFFF, 16'hFFFF);
                queue_command(OP_UNUSED_FIRST, 8'd5, 16'h0000, 16'h0000);
                queue_command(OP_UNUSED_LAST, 8'd254, 16'hFFFF, 16'hFFFF);
                queue_command(OP_PING,       8'd200, 16'h0000, 16'h0000);
            end
            queue_random((phase == 2) ? 25 : 28);

            // Let the phase drain before the idling pattern changes.
            @(negedge clk);
            while (command_queue.size() != 0 || in_valid || expected_bytes.size() != 0)
                @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_bytes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
